FILE: rtl/core/branch_unit_with_call_stack_defines.svh
// Assertion macros shared by the branch unit RTL.
// Users must have clk and rst_n in scope.
`ifndef BRANCH_UNIT_WITH_CALL_STACK_DEFINES_SVH
`define BRANCH_UNIT_WITH_CALL_STACK_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BUCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BUCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bucs_pkg.sv
// Package for the branch unit: item types, operation and error codes,
// stack sizing and the stack control/status structs. No dependencies.
`default_nettype none

package bucs_pkg;

    localparam int STACK_WORDS = 256;
    localparam int SP_W        = $clog2(STACK_WORDS + 1);
    localparam int ADDR_W      = $clog2(STACK_WORDS);

    localparam logic [3:0] FUNC_JMP  = 4'd0;
    localparam logic [3:0] FUNC_JEQ  = 4'd1;
    localparam logic [3:0] FUNC_JNE  = 4'd2;
    localparam logic [3:0] FUNC_JGT  = 4'd3;
    localparam logic [3:0] FUNC_JGE  = 4'd4;
    localparam logic [3:0] FUNC_JLT  = 4'd5;
    localparam logic [3:0] FUNC_JLE  = 4'd6;
    localparam logic [3:0] FUNC_JHI  = 4'd7;
    localparam logic [3:0] FUNC_JHE  = 4'd8;
    localparam logic [3:0] FUNC_JLO  = 4'd9;
    localparam logic [3:0] FUNC_JLOE = 4'd10;
    localparam logic [3:0] FUNC_CALL = 4'd11;
    localparam logic [3:0] FUNC_RET  = 4'd12;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_STACK   = 2'd1;
    localparam logic [1:0] ERR_INVALID = 2'd2;

    typedef struct packed {
        logic [3:0]         func;
        logic               reg_mode;
        logic [31:0]        reg_value;
        logic signed [23:0] imm_offset;
        logic [31:0]        current_pc;
        logic               flag_z;
        logic               flag_n;
        logic               flag_c;
        logic               flag_v;
    } bu_in_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        taken;
        logic [1:0]  error_code;
    } bu_out_t;

    // Decoded operation
    typedef struct packed {
        logic jump;      // conditional/unconditional jump, condition true
        logic is_call;
        logic is_ret;
        logic invalid;
    } bu_dec_t;

    typedef struct packed {
        logic        push;
        logic        pop;
        logic [31:0] push_data;
    } stk_req_t;

    typedef struct packed {
        logic        full;
        logic        empty;
        logic [31:0] top;
    } stk_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/bucs_decode.sv
// Operation decode, flag condition test and branch target computation.
// Uses bucs_pkg.
`default_nettype none

module bucs_decode
    import bucs_pkg::*;
(
    input  bu_in_t      item,
    output bu_dec_t     dec,
    output logic [31:0] target
);

    logic [31:0] offset_bytes;

    // sign-extended word offset, scaled to bytes
    assign offset_bytes = {{6{item.imm_offset[23]}}, item.imm_offset, 2'b00};
    assign target = item.reg_mode ? item.reg_value
                                  : item.current_pc - 32'd4 + offset_bytes;

    always_comb
    begin
        dec = '0;
        case (item.func)
            FUNC_JMP:  dec.jump = 1'b1;
            FUNC_JEQ:  dec.jump = item.flag_z;
            FUNC_JNE:  dec.jump = !item.flag_z;
            FUNC_JGT:  dec.jump = !item.flag_z && (item.flag_n == item.flag_v);
            FUNC_JGE:  dec.jump = (item.flag_n == item.flag_v);
            FUNC_JLT:  dec.jump = (item.flag_n != item.flag_v);
            FUNC_JLE:  dec.jump = item.flag_z || (item.flag_n != item.flag_v);
            // carry is a borrow flag: higher means no borrow
            FUNC_JHI:  dec.jump = !item.flag_z && !item.flag_c;
            FUNC_JHE:  dec.jump = !item.flag_c;
            FUNC_JLO:  dec.jump = item.flag_c;
            FUNC_JLOE: dec.jump = item.flag_z || item.flag_c;
            FUNC_CALL: dec.is_call = 1'b1;
            FUNC_RET:  dec.is_ret = 1'b1;
            default:   dec.invalid = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/bucs_stack.sv
// Return-address stack: stack pointer, word memory and a registered
// top-of-stack read with write bypass. Uses bucs_pkg.
`default_nettype none

module bucs_stack
    import bucs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  stk_req_t  req,
    output stk_stat_t stat
);

    logic [SP_W-1:0]   sp_reg;
    logic [SP_W-1:0]   sp_next;
    logic [ADDR_W-1:0] rd_addr;
    logic [31:0]       mem [0:STACK_WORDS-1];
    logic [31:0]       rd_data_reg;
    logic              byp_reg;
    logic [31:0]       byp_data_reg;

    // sp counts free words; entry at sp is the top
    always_comb
    begin
        sp_next = sp_reg;
        if (req.push)
            sp_next = sp_reg - SP_W'(1);
        else if (req.pop)
            sp_next = sp_reg + SP_W'(1);
    end

    // prefetch the top for the next cycle; empty-stack address is don't-care
    assign rd_addr = sp_next[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg  <= SP_W'(STACK_WORDS);
            byp_reg <= 1'b0;
        end
        else
        begin
            sp_reg  <= sp_next;
            byp_reg <= req.push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.push)
            mem[sp_next[ADDR_W-1:0]] <= req.push_data;
        rd_data_reg  <= mem[rd_addr];
        byp_data_reg <= req.push_data;
    end

    assign stat.full  = (sp_reg == '0);
    assign stat.empty = (sp_reg == SP_W'(STACK_WORDS));
    assign stat.top   = byp_reg ? byp_data_reg : rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/branch_unit_with_call_stack.sv
// Branch unit with return-address stack (uses bucs_pkg, bucs_decode, bucs_stack).
// Pipeline: an accepted req enters the input register, then moves to the result register.
// Throughput: one item per cycle when rsp_stall is low, including back-to-back call/ret;
// the stack top is prefetched from the memory's registered read port with a write bypass.
// Reset: async active low; empties the stack and both pipeline registers.
// Stack memory is not cleared; only pushed entries are ever read.
`default_nettype none

`include "branch_unit_with_call_stack_defines.svh"

module branch_unit_with_call_stack
    import bucs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_stall,
    input  bu_in_t  req,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    output bu_out_t rsp
);

    // input register
    logic      in_valid_reg;
    logic      in_valid_next;
    bu_in_t    in_item_reg;

    // result register
    logic      out_valid_reg;
    logic      out_valid_next;
    bu_out_t   out_item_reg;

    logic        adv;       // item in the input register moves to the result register
    logic        accept;
    bu_dec_t     dec;
    logic [31:0] target;
    stk_req_t    stk_req;
    stk_stat_t   stk_stat;
    bu_out_t     result;

    assign adv       = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !adv;
    assign accept    = req_valid && !req_stall;

    bucs_decode u_decode (
        .item   (in_item_reg),
        .dec    (dec),
        .target (target)
    );

    bucs_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (stk_req),
        .stat  (stk_stat)
    );

    // Resolve the item. Stack state only moves when the item advances.
    always_comb
    begin
        result.next_pc    = in_item_reg.current_pc;
        result.taken      = 1'b0;
        result.error_code = ERR_NONE;
        stk_req.push      = 1'b0;
        stk_req.pop       = 1'b0;
        stk_req.push_data = in_item_reg.current_pc;

        if (dec.jump)
        begin
            result.next_pc = target;
            result.taken   = 1'b1;
        end
        else if (dec.is_call)
        begin
            if (stk_stat.full)
                result.error_code = ERR_STACK;
            else
            begin
                result.next_pc = target;
                result.taken   = 1'b1;
                stk_req.push   = adv;
            end
        end
        else if (dec.is_ret)
        begin
            if (stk_stat.empty)
                result.error_code = ERR_STACK;
            else
            begin
                result.next_pc = stk_stat.top;
                result.taken   = 1'b1;
                stk_req.pop    = adv;
            end
        end
        else if (dec.invalid)
            result.error_code = ERR_INVALID;
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (adv)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (!rsp_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= req;
        if (adv)
            out_item_reg <= result;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    // A push must never happen on a full stack, nor a pop on an empty one.
    `BUCS_ASSERT_NOW(a_no_push_full, stk_req.push, !stk_stat.full, "push on full stack")
    `BUCS_ASSERT_NOW(a_no_pop_empty, stk_req.pop, !stk_stat.empty, "pop on empty stack")
    // The bypass must present a just-pushed return address as the new top.
    `BUCS_ASSERT_NEXT(a_push_top, stk_req.push, stk_stat.top == $past(stk_req.push_data), "stack top not bypassed after push")
    // A taken result never carries an error.
    `BUCS_ASSERT_NOW(a_taken_ok, adv && result.taken, result.error_code == ERR_NONE, "taken with error")
    // An advancing item always lands in the result register.
    `BUCS_ASSERT_NEXT(a_adv_valid, adv, rsp_valid, "result lost")

endmodule

`default_nettype wire
